// ===== hdl/uart_frame_deframer_unit_assert.svh =====
// Assertion macros used by the deframer controller.
`ifndef UART_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define UART_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UFD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ufd_pkg.sv =====
`default_nettype none
package ufd_pkg;

  localparam int MAX_LEN    = 16;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 8;
  localparam int IDX_W      = $clog2(MAX_LEN);
  localparam int BYTE_IDX_W = 4;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAIL  = 1'b1;

  localparam logic [BYTE_W-1:0] HEADER_RST = 8'h02;
  localparam logic [BYTE_W-1:0] TRAIL_RST  = 8'h03;

  typedef struct packed {
    logic load_len;
    logic load_code;
    logic load_data;
    logic clr_idx;
    logic rd;
    logic ld_out;
    logic inc_idx;
  } ufd_cmd_t;

  typedef struct packed {
    logic hdr_match;
    logic len_ok;
    logic len_is_one;
    logic data_last;
    logic sum_ok;
    logic trail_ok;
    logic out_free;
    logic emit_last;
  } ufd_sts_t;

endpackage
`default_nettype wire

// ===== hdl/ufd_ctrl.sv =====
`default_nettype none
module ufd_ctrl
  import ufd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire ufd_sts_t sts,
  output ufd_cmd_t      cmd
);

  `include "uart_frame_deframer_unit_assert.svh"

  localparam logic [2:0] ST_HUNT  = 3'd0;
  localparam logic [2:0] ST_LEN   = 3'd1;
  localparam logic [2:0] ST_CODE  = 3'd2;
  localparam logic [2:0] ST_DATA  = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam logic [2:0] ST_TRAIL = 3'd5;
  localparam logic [2:0] ST_RD    = 3'd6;
  localparam logic [2:0] ST_LD    = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       in_fire;

  assign in_ready = (state_r != ST_RD) && (state_r != ST_LD);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_HUNT: begin
        if (in_fire && sts.hdr_match) state_nxt = ST_LEN;
      end
      ST_LEN: begin
        if (in_fire) begin
          if (sts.len_ok) begin
            cmd.load_len = 1'b1;
            state_nxt    = ST_CODE;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_CODE: begin
        if (in_fire) begin
          cmd.load_code = 1'b1;
          state_nxt     = sts.len_is_one ? ST_SUM : ST_DATA;
        end
      end
      ST_DATA: begin
        if (in_fire) begin
          cmd.load_data = 1'b1;
          if (sts.data_last) state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (in_fire) state_nxt = sts.sum_ok ? ST_TRAIL : ST_HUNT;
      end
      ST_TRAIL: begin
        if (in_fire) begin
          if (sts.trail_ok) begin
            cmd.clr_idx = 1'b1;
            // A frame without data skips the payload read.
            state_nxt   = sts.len_is_one ? ST_LD : ST_RD;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_LD;
      end
      ST_LD: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          if (sts.emit_last) begin
            state_nxt = ST_HUNT;
          end else begin
            cmd.inc_idx = 1'b1;
            state_nxt   = ST_RD;
          end
        end
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  `UFD_ASSERT_NEXT(a_good_trail_emits,
    (state_r == ST_TRAIL) && in_fire && sts.trail_ok,
    (state_r == ST_RD) || (state_r == ST_LD),
    "good trail did not start emission")
  `UFD_ASSERT_NEXT(a_last_returns_hunt,
    cmd.ld_out && sts.emit_last,
    state_r == ST_HUNT,
    "last result did not return to hunting")
  `UFD_ASSERT_NEXT(a_stall_holds_load,
    (state_r == ST_LD) && !sts.out_free,
    state_r == ST_LD,
    "pending result lost while output stalled")

endmodule
`default_nettype wire

// ===== hdl/ufd_dpath.sv =====
`default_nettype none
module ufd_dpath
  import ufd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0] cfg_data,
  input  wire ufd_cmd_t          cmd,
  output ufd_sts_t               sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_frame_code,
  output logic [BYTE_W-1:0]      out_data_byte,
  output logic [BYTE_IDX_W-1:0]  out_byte_index,
  output logic                   out_has_data,
  output logic                   out_last
);

  logic [BYTE_W-1:0]     header_r, trail_r;
  logic [LEN_W-1:0]      len_r;
  logic [BYTE_W-1:0]     code_r;
  logic [BYTE_W-1:0]     sum_r;
  logic [IDX_W-1:0]      cnt_r;
  logic [IDX_W-1:0]      idx_r;
  logic [BYTE_W-1:0]     rd_data_r;
  logic [BYTE_W-1:0]     mem [MAX_LEN];
  logic                  out_valid_r;
  logic [BYTE_W-1:0]     out_code_r, out_data_r;
  logic [BYTE_IDX_W-1:0] out_idx_r;
  logic                  out_has_r, out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RST;
      trail_r  <= TRAIL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER: header_r <= cfg_data;
        CFG_TRAIL:  trail_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      code_r <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
      idx_r  <= '0;
    end else begin
      if (cmd.load_len) begin
        len_r <= in_byte;
        sum_r <= in_byte;
      end
      if (cmd.load_code) begin
        code_r <= in_byte;
        sum_r  <= sum_r + in_byte;
        cnt_r  <= '0;
      end
      if (cmd.load_data) begin
        sum_r <= sum_r + in_byte;
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.clr_idx) idx_r <= '0;
      if (cmd.inc_idx) idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_data) mem[cnt_r] <= in_byte;
    if (cmd.rd) rd_data_r <= mem[idx_r];
  end

  always_comb begin
    sts.hdr_match  = (in_byte == header_r);
    sts.len_ok     = (in_byte != '0) && (in_byte < LEN_W'(MAX_LEN));
    sts.len_is_one = (len_r == LEN_W'(1));
    sts.data_last  = (LEN_W'(cnt_r) + LEN_W'(2) >= len_r);
    sts.sum_ok     = (in_byte == sum_r);
    sts.trail_ok   = (in_byte == trail_r);
    sts.out_free   = !out_valid_r || out_ready;
    sts.emit_last  = sts.len_is_one || (LEN_W'(idx_r) + LEN_W'(2) == len_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_code_r <= code_r;
      out_data_r <= sts.len_is_one ? '0 : rd_data_r;
      out_idx_r  <= sts.len_is_one ? '0 : BYTE_IDX_W'(idx_r);
      out_has_r  <= !sts.len_is_one;
      out_last_r <= sts.emit_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_code = out_code_r;
  assign out_data_byte  = out_data_r;
  assign out_byte_index = out_idx_r;
  assign out_has_data   = out_has_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire

// ===== hdl/uart_frame_deframer_unit.sv =====
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_rx_byte
// out      output     out_valid / out_ready  out_frame_code, out_data_byte,
//                                            out_byte_index, out_has_data, out_last
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// While the frame parser runs, in_ready is high and a byte is taken whenever
// in_valid is high. After a good trail byte, each payload result passes
// through a payload memory read, then an output register load, and no byte
// is taken meanwhile; a frame without data needs only the load.
// A stalled output holds the sequencer; the last result of a frame may wait
// in the output register while the next bytes are taken.
// Reset is synchronous; the payload memory needs no clearing.
`default_nettype none
module uart_frame_deframer_unit
  import ufd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [BYTE_W-1:0]     in_rx_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [BYTE_W-1:0]          out_frame_code,
  output logic [BYTE_W-1:0]          out_data_byte,
  output logic [BYTE_IDX_W-1:0]      out_byte_index,
  output logic                       out_has_data,
  output logic                       out_last,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [BYTE_W-1:0]     cfg_data
);

  ufd_cmd_t cmd;
  ufd_sts_t sts;

  ufd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ufd_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_byte        (in_rx_byte),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_code (out_frame_code),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_has_data   (out_has_data),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire
